// ===== sv/gdrc_pkg.sv =====
// Package: shared types and constants of the grid DDA ray caster.
package gdrc_pkg;
    localparam int unsigned FRAC_BITS = 11;
    localparam int unsigned SIDE_W    = 40;
    localparam logic [31:0] DELTA_SAT = 32'hFFFF_FFFF;
    localparam logic [15:0] DIST_MAX  = 16'hFFFF;
    localparam logic        REQ_WRITE = 1'b0;
    localparam logic        REQ_CAST  = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [4:0]  cell_x;
        logic [4:0]  cell_y;
        logic [2:0]  cell_type;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic signed [15:0] dir_cos;
        logic signed [15:0] dir_sin;
    } t_req;

    typedef struct packed {
        logic [15:0] wall_distance;
        logic        hit_face;
        logic [2:0]  wall_kind;
    } t_res;

    // Handshake between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic [15:0] divisor;
    } t_div_cmd;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_sts;
endpackage

// ===== sv/gdrc_if.sv =====
// Interfaces: valid/ready channels for request and result words.
interface gdrc_req_if;
    import gdrc_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gdrc_res_if;
    import gdrc_pkg::*;
    logic valid;
    logic ready;
    t_res data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/gdrc_div.sv =====
// Module: restoring divider computing 2^30 / divisor, one quotient bit a cycle.
module gdrc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  gdrc_pkg::t_div_cmd i_cmd,
    output gdrc_pkg::t_div_sts o_sts
);
    import gdrc_pkg::*;

    logic [16:0] r_rem, n_rem;
    logic [30:0] r_quo, n_quo;
    logic [15:0] r_dvs;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [16:0] w_try;

    // Shift in the next dividend bit: only bit 30 of 2^30 is set.
    always_comb begin
        w_try = {r_rem[15:0], (r_cnt == 5'd0)};
        n_rem = w_try;
        n_quo = {r_quo[29:0], 1'b0};
        if (w_try >= {1'b0, r_dvs}) begin
            n_rem = w_try - {1'b0, r_dvs};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_rem  <= 17'd0;
                r_quo  <= 31'd0;
                r_dvs  <= i_cmd.divisor;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd30) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_sts.done     = r_done;
    assign o_sts.quotient = (r_dvs == 16'd0) ? DELTA_SAT : {1'b0, r_quo};
endmodule

// ===== sv/grid_dda_ray_caster.sv =====
// Top level: tile map, DDA sequencer and shared divider of the ray caster.
//
//  channel  dir  word contents
//  i_req    in   req_type, cell_x/y, cell_type, origin_x/y, dir_cos/sin
//  o_res    out  wall_distance, hit_face, wall_kind
//
// A write is taken in idle. A cast computes the two reciprocals on the shared
// serial divider, then multiplies out both first crossings, then walks the DDA
// steps (map read, then compare) and finally loads the result word.
// Reset clears the sequencer; the map is undefined until written.
// The result waits in an output register; a stalled result holds the
// next cast in S_OUT until the register frees up.
module grid_dda_ray_caster #(
    parameter int MAP_SIDE  = 32,
    parameter int MAX_STEPS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gdrc_req_if.sink    i_req,
    gdrc_res_if.source  o_res
);
    import gdrc_pkg::*;

    localparam int AW = $clog2(MAP_SIDE);
    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam int CW = $clog2(MAX_STEPS + 32) + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIVX = 3'd1;
    localparam logic [2:0] S_DIVY = 3'd2;
    localparam logic [2:0] S_SIDE = 3'd3;
    localparam logic [2:0] S_STEP = 3'd4;
    localparam logic [2:0] S_READ = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0]  r_state;
    t_req        r_req;
    logic [31:0] r_dx, r_dy;
    logic [SIDE_W-1:0] r_sx, r_sy, r_here;
    logic signed [CW-1:0] r_cx, r_cy;
    logic        r_face;
    logic [SW-1:0] r_cnt;
    logic        r_out_valid;
    t_res        r_res;
    logic [2:0]  r_map [1 << (2*AW)];
    logic [2:0]  r_rd;
    logic        r_oob;
    t_div_cmd    w_cmd;
    t_div_sts    w_sts;
    logic        r_started;
    logic        w_load;
    logic [AW-1:0] w_wx, w_wy;

    gdrc_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts));

    function automatic logic [15:0] f_mag(input logic signed [15:0] d);
        return d[15] ? 16'(-d) : d;
    endfunction

    function automatic logic [11:0] f_gap(input logic [15:0] o, input logic neg);
        return neg ? {1'b0, o[10:0]} : 12'd2048 - {1'b0, o[10:0]};
    endfunction

    assign i_req.ready = (r_state == S_IDLE);
    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    // Load the result word once the output register is free.
    assign w_load = (r_state == S_OUT) && (!r_out_valid || o_res.ready);

    always_comb begin
        w_cmd.start   = (r_state == S_DIVX || r_state == S_DIVY) && !r_started;
        w_cmd.divisor = (r_state == S_DIVY) ? f_mag(r_req.dir_sin) : f_mag(r_req.dir_cos);
    end

    // Write the map, and read the cell the walk enters.
    logic signed [CW-1:0] w_ncx, w_ncy;
    logic        w_takex;
    assign w_takex = r_sx < r_sy;
    assign w_ncx = w_takex ? (r_req.dir_cos[15] ? r_cx - CW'(1) : r_cx + CW'(1)) : r_cx;
    assign w_ncy = w_takex ? r_cy : (r_req.dir_sin[15] ? r_cy - CW'(1) : r_cy + CW'(1));
    assign w_wx  = AW'(i_req.data.cell_x);
    assign w_wy  = AW'(i_req.data.cell_y);

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready && i_req.data.req_type == REQ_WRITE &&
            32'(i_req.data.cell_x) < MAP_SIDE && 32'(i_req.data.cell_y) < MAP_SIDE)
            r_map[{w_wy, w_wx}] <= i_req.data.cell_type;
        if (r_state == S_STEP) begin
            r_rd  <= r_map[{AW'(w_ncy), AW'(w_ncx)}];
            r_oob <= (w_ncx < 0) || (32'(w_ncx) >= MAP_SIDE) ||
                     (w_ncy < 0) || (32'(w_ncy) >= MAP_SIDE);
        end
    end

    logic [2:0]  w_kind;
    logic [SIDE_W-8:0] w_dist;
    assign w_kind = r_oob ? 3'd1 : r_rd;
    assign w_dist = r_here[SIDE_W-1:7];

    // Sequence one cast word through setup, walk and result; a write stays in idle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_started   <= 1'b0;
        end else begin
            r_out_valid <= w_load || (r_out_valid && !o_res.ready);
            unique case (r_state)
                S_IDLE: if (i_req.valid && i_req.ready) begin
                    r_req <= i_req.data;
                    r_cx  <= CW'(i_req.data.origin_x[15:11]);
                    r_cy  <= CW'(i_req.data.origin_y[15:11]);
                    r_cnt <= '0;
                    if (i_req.data.req_type == REQ_CAST) r_state <= S_DIVX;
                end
                S_DIVX, S_DIVY: begin
                    r_started <= !w_sts.done;
                    if (w_sts.done) begin
                        if (r_state == S_DIVX) begin
                            r_dx <= w_sts.quotient;
                            r_state <= S_DIVY;
                        end else begin
                            r_dy <= w_sts.quotient;
                            r_state <= S_SIDE;
                        end
                    end
                end
                S_SIDE: begin
                    r_sx <= SIDE_W'((44'(f_gap(r_req.origin_x, r_req.dir_cos[15])) * r_dx)
                            >> FRAC_BITS);
                    r_sy <= SIDE_W'((44'(f_gap(r_req.origin_y, r_req.dir_sin[15])) * r_dy)
                            >> FRAC_BITS);
                    r_state <= S_STEP;
                end
                S_STEP: begin
                    r_cx <= w_ncx;
                    r_cy <= w_ncy;
                    r_face <= !w_takex;
                    r_cnt <= r_cnt + SW'(1);
                    if (w_takex) begin
                        r_here <= r_sx;
                        r_sx <= r_sx + SIDE_W'(r_dx);
                    end else begin
                        r_here <= r_sy;
                        r_sy <= r_sy + SIDE_W'(r_dy);
                    end
                    r_state <= S_READ;
                end
                S_READ: begin
                    if (w_kind != 3'd0 || 32'(r_cnt) == MAX_STEPS) r_state <= S_OUT;
                    else r_state <= S_STEP;
                end
                S_OUT: if (w_load) begin
                    r_res.hit_face  <= r_face;
                    r_res.wall_kind <= w_kind;
                    if (w_kind == 3'd0 || w_dist == '0)
                        r_res.wall_distance <= 16'd1;
                    else if (w_dist > (SIDE_W-7)'(DIST_MAX))
                        r_res.wall_distance <= DIST_MAX;
                    else
                        r_res.wall_distance <= w_dist[15:0];
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sim/testbench.sv =====
// Testbench: checks the grid DDA ray caster against its own cast predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gdrc_pkg::*;

    localparam int SIDE  = 32;
    localparam int STEPS = 64;

    logic i_clk;
    logic i_rst_n;

    gdrc_req_if req_ch ();
    gdrc_res_if res_ch ();

    grid_dda_ray_caster #(.MAP_SIDE(SIDE), .MAX_STEPS(STEPS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    // Predictor state and the queue of expected result words.
    logic [2:0] map_shadow [SIDE*SIDE];
    t_res       pending_res [$];
    int         fail_cnt;
    bit         stim_done;
    bit         hold_off;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAILED: results differ");
        $finish;
    end

    // Set up one axis of the walk: step length, first crossing, direction, cell.
    function automatic void axis_init(input logic [15:0] org,
                                      input logic signed [15:0] d,
                                      output logic [63:0] dlt, output logic [63:0] sd,
                                      output int stp, output int cel);
        logic [10:0] frac;
        logic [31:0] mag;
        logic [31:0] gap;
        frac = org[10:0];
        mag  = 32'((d < 0) ? -int'(d) : int'(d));
        cel  = int'(org[15:11]);
        dlt  = (mag == 0) ? 64'(DELTA_SAT) : (64'd1 << 30) / mag;
        if (d < 0) begin
            stp = -1;
            gap = 32'(frac);
        end else begin
            stp = 1;
            gap = 32'd2048 - 32'(frac);
        end
        sd = (64'(gap) * dlt) >> FRAC_BITS;
    endfunction

    // Walk the grid for one cast and return the expected result word.
    function automatic t_res predict_cast(t_req r);
        logic [63:0] dx, dy, sx, sy, here, hit_dist;
        int stx, sty, cx, cy;
        logic [2:0] kind;
        logic face;
        t_res o;
        hit_dist = 0;
        kind = 0;
        face = 0;
        axis_init(r.origin_x, r.dir_cos, dx, sx, stx, cx);
        axis_init(r.origin_y, r.dir_sin, dy, sy, sty, cy);
        for (int i = 0; i < STEPS; i++) begin
            if (sx < sy) begin
                here = sx; sx += dx; cx += stx; face = 0;
            end else begin
                here = sy; sy += dy; cy += sty; face = 1;
            end
            if (cx < 0 || cx >= SIDE || cy < 0 || cy >= SIDE) kind = 3'd1;
            else kind = map_shadow[cy*SIDE + cx];
            if (kind != 0) begin
                hit_dist = here >> 7;
                break;
            end
        end
        if (kind == 0) o.wall_distance = 16'd1;
        else if (hit_dist > 64'(DIST_MAX)) o.wall_distance = DIST_MAX;
        else if (hit_dist < 1) o.wall_distance = 16'd1;
        else o.wall_distance = hit_dist[15:0];
        o.hit_face  = face;
        o.wall_kind = kind;
        return o;
    endfunction

    // Drive one request word at the falling edge and hold until taken.
    task automatic send_word(input t_req r);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) gap = 0;
        // Drop valid over the idle gap, then offer the word.
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        if (r.req_type == REQ_WRITE) begin
            if (r.cell_x < SIDE && r.cell_y < SIDE)
                map_shadow[r.cell_y*SIDE + r.cell_x] = r.cell_type;
        end else begin
            pending_res.insert(pending_res.size(), predict_cast(r));
        end
        @(negedge i_clk);
    endtask

    function automatic t_req make_write(int x, int y, int k);
        t_req r;
        r = '0;
        r.req_type  = REQ_WRITE;
        r.cell_x    = 5'(x);
        r.cell_y    = 5'(y);
        r.cell_type = 3'(k);
        r.origin_x  = 16'($urandom);
        r.origin_y  = 16'($urandom);
        r.dir_cos   = 16'($urandom);
        r.dir_sin   = 16'($urandom);
        return r;
    endfunction

    function automatic t_req make_cast(logic [15:0] ox, logic [15:0] oy,
                                       logic signed [15:0] c, logic signed [15:0] s);
        t_req r;
        r.req_type  = REQ_CAST;
        r.cell_x    = 5'($urandom);
        r.cell_y    = 5'($urandom);
        r.cell_type = 3'($urandom);
        r.origin_x  = ox;
        r.origin_y  = oy;
        r.dir_cos   = c;
        r.dir_sin   = s;
        return r;
    endfunction

    // Random unit-ish direction; sometimes an axis, sometimes an extreme.
    function automatic t_req rand_cast();
        int c, s, pick;
        pick = $urandom_range(0, 9);
        c = $urandom_range(0, 32768) - 16384;
        s = $urandom_range(0, 32768) - 16384;
        if (pick == 0) c = 0;
        if (pick == 1) s = 0;
        if (pick == 2) c = ($urandom_range(0, 1)) ? 16384 : -16384;
        return make_cast(16'($urandom), 16'($urandom), 16'(c), 16'(s));
    endfunction

    // Directed rows: cast, then the result where it is obvious (0 = use predictor).
    typedef struct {
        logic [15:0] ox, oy;
        logic signed [15:0] dc, ds;
        bit          typed;
        t_res        want;
    } t_row;

    t_row rows [] = '{
        '{16'h0400, 16'h0400, -16'sd16384, 16'sd0,  1'b1, '{16'd256, 1'b0, 3'd1}},
        '{16'h0400, 16'h0400, 16'sd0, -16'sd16384,  1'b1, '{16'd256, 1'b1, 3'd1}},
        '{16'h0400, 16'h0400, 16'sd0, 16'sd0,       1'b0, '{16'd0, 1'b0, 3'd0}},
        '{16'hFFFF, 16'hFFFF, 16'sd16384, 16'sd16384, 1'b0, '{16'd0, 1'b0, 3'd0}},
        '{16'h0000, 16'h0000, -16'sd16384, -16'sd16384, 1'b0, '{16'd0, 1'b0, 3'd0}},
        '{16'h8000, 16'h8000, 16'sd1, 16'sd0,      1'b0, '{16'd0, 1'b0, 3'd0}},
        '{16'h8000, 16'h8000, 16'sd0, -16'sd1,     1'b0, '{16'd0, 1'b0, 3'd0}},
        '{16'h8000, 16'h8000, 16'sd11585, 16'sd11585, 1'b0, '{16'd0, 1'b0, 3'd0}},
        '{16'h7FFF, 16'h0001, -16'sd11585, 16'sd11585, 1'b0, '{16'd0, 1'b0, 3'd0}},
        '{16'h0800, 16'h0800, -16'sd16384, 16'sd0, 1'b0, '{16'd0, 1'b0, 3'd0}}
    };

    // Check each result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_res exp_w;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_res.size() == 0) begin
                $display("%0t: unexpected result %h", $time, res_ch.data);
                fail_cnt++;
            end else begin
                exp_w = pending_res.pop_front();
                if (res_ch.data.wall_distance !== exp_w.wall_distance) begin
                    $display("%0t: wall_distance expected %0d actual %0d", $time,
                             exp_w.wall_distance, res_ch.data.wall_distance);
                    fail_cnt++;
                end
                if (res_ch.data.hit_face !== exp_w.hit_face) begin
                    $display("%0t: hit_face expected %0d actual %0d", $time,
                             exp_w.hit_face, res_ch.data.hit_face);
                    fail_cnt++;
                end
                if (res_ch.data.wall_kind !== exp_w.wall_kind) begin
                    $display("%0t: wall_kind expected %0d actual %0d", $time,
                             exp_w.wall_kind, res_ch.data.wall_kind);
                    fail_cnt++;
                end
            end
        end
    end

    // Stall the result side at random, with one long hold-off.
    initial begin
        int n;
        res_ch.ready = 1'b0;
        @(posedge i_rst_n);
        while (!stim_done) begin
            @(negedge i_clk);
            if (hold_off) begin
                res_ch.ready <= 1'b0;
                for (n = 0; n < 600; n++) @(negedge i_clk);
                hold_off = 1'b0;
            end
            if ($urandom_range(0, 2) == 0) begin
                res_ch.ready <= 1'b0;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4);
                repeat (n) @(negedge i_clk);
            end
            res_ch.ready <= 1'b1;
        end
        @(negedge i_clk);
        res_ch.ready <= 1'b1;
    end

    // Main sequence: fill map, directed casts, random traffic, drain.
    initial begin
        t_req r;
        int wait_cnt;
        fail_cnt = 0;
        stim_done = 0;
        hold_off = 0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Clear the whole map, then set two corner cells to different wall types.
        for (int y = 0; y < SIDE; y++)
            for (int x = 0; x < SIDE; x++)
                send_word(make_write(x, y, 0));
        send_word(make_write(31, 31, 7));
        send_word(make_write(0, 31, 4));

        foreach (rows[i]) begin
            r = make_cast(rows[i].ox, rows[i].oy, rows[i].dc, rows[i].ds);
            send_word(r);
            if (rows[i].typed && pending_res.size() > 0)
                pending_res[$] = rows[i].want;
        end

        // Random part: sparse walls, mostly casts; long stall once.
        for (int k = 0; k < 300; k++) begin
            if (k == 100) hold_off = 1'b1;
            if ($urandom_range(0, 3) == 0)
                send_word(make_write($urandom, $urandom,
                          ($urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0));
            else
                send_word(rand_cast());
        end
        req_ch.valid <= 1'b0;
        stim_done = 1'b1;

        wait_cnt = 0;
        while (pending_res.size() > 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (300) @(posedge i_clk);
        if (fail_cnt == 0 && pending_res.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end
endmodule

// ===== grid_dda_ray_caster.f =====
sv/gdrc_pkg.sv
sv/gdrc_if.sv
sv/gdrc_div.sv
sv/grid_dda_ray_caster.sv
sim/testbench.sv
